### design/ksa_pkg.sv
// Shared types, scan code constants and key tables for the set 1 scan code decoder.
// No dependencies.
package ksa_pkg;

    localparam int KEY_COUNT  = 59;
    localparam int IDX_W      = 6;
    localparam int CHAR_W     = 7;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    localparam logic [7:0] PREFIX_BYTE  = 8'he0;
    localparam logic [6:0] KEY_LCTRL    = 7'h1d;
    localparam logic [6:0] KEY_LSHIFT   = 7'h2a;
    localparam logic [6:0] KEY_RSHIFT   = 7'h36;
    localparam logic [6:0] KEY_ALT      = 7'h38;
    localparam logic [6:0] KEY_CAPS     = 7'h3a;
    localparam logic [7:0] KEY_LIMIT    = 8'h3b;

    typedef struct packed {
        logic prefix_pending;
        logic ctrl_down;
        logic shift_down;
        logic alt_down;
        logic caps_lock_on;
    } ksa_state_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] ascii_char;
        logic              unknown_key;
        logic              ctrl_held;
        logic              shift_held;
        logic              alt_held;
        logic              caps_on;
    } ksa_result_t;

    localparam logic [7:0] PLAIN_COL [KEY_COUNT] = '{
        8'h00, 8'h1b, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08, 8'h09,
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0d, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, 8'h00, 8'h5c, "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " ", 8'h00
    };

    localparam logic [7:0] SHIFTED_COL [KEY_COUNT] = '{
        8'h00, 8'h1b, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h08, 8'h09,
        "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0d, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "?", 8'h00, "*", 8'h00, " ", 8'h00
    };

    // digits and punctuation: case follows shift alone
    function automatic logic shift_only_key(input logic [7:0] code);
        logic r;
        case (code) inside
            [8'h00:8'h0d],
            8'h1a, 8'h1b, 8'h27, 8'h28, 8'h29, 8'h2b,
            8'h33, 8'h34, 8'h35: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] key_char(input logic [IDX_W-1:0] idx,
                                                   input logic            shifted);
        logic [CHAR_W-1:0] r;
        r = '0;
        if (32'(idx) < KEY_COUNT) begin
            r = shifted ? SHIFTED_COL[idx][CHAR_W-1:0] : PLAIN_COL[idx][CHAR_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/keyboard_scancode_to_ascii.sv
// Set 1 keyboard scan code to ASCII decoder, one result beat per scan code beat.
// Each scan code beat is held in the input register, then decoded into the result register,
// which drives m_tvalid and m_tdata.
// Throughput: one beat per cycle unless m_tready stalls; decode logic is combinational.
// Reset (aresetn low, synchronous) empties both stages and clears prefix, modifiers, caps.
// Depends on ksa_pkg, ksa_in_reg, ksa_core, ksa_out_reg.
module keyboard_scancode_to_ascii (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ksa_pkg::S_TDATA_W-1:0]   s_tdata,    // [7:0] scan_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] char_valid, [7:1] ascii_char, [8] unknown_key, [9] ctrl_held,
    // [10] shift_held, [11] alt_held, [12] caps_on, [15:13] zero
    output logic [ksa_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ksa_pkg::*;

    logic        advance;
    logic        in_valid;
    logic [7:0]  in_byte;
    ksa_result_t result;

    ksa_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    ksa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (in_valid && advance),
        .in_byte (in_byte),
        .result  (result)
    );

    ksa_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### design/ksa_in_reg.sv
// Input register stage: holds one accepted scan code beat.
// Depends on ksa_pkg.
module ksa_in_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ksa_pkg::S_TDATA_W-1:0]   s_tdata,    // [7:0] scan_byte
    input  logic                            advance,
    output logic                            in_valid,
    output logic [7:0]                      in_byte
);
    import ksa_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                byte_next = s_tdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

### design/ksa_core.sv
// Decode logic and keyboard state: prefix, modifiers and caps lock, table lookup.
// Depends on ksa_pkg.
module ksa_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    output ksa_pkg::ksa_result_t result
);
    import ksa_pkg::*;

    ksa_state_t        state_reg, state_next;
    logic [6:0]        low;
    logic              prefixed;
    logic              handled;
    logic              use_shift;
    logic [CHAR_W-1:0] ch;
    logic              unknown;

    assign low      = in_byte[6:0];
    assign prefixed = state_reg.prefix_pending;

    always_comb begin
        state_next = state_reg;
        ch         = '0;
        unknown    = 1'b0;
        handled    = 1'b0;
        use_shift  = 1'b0;
        if (in_byte == PREFIX_BYTE) begin
            state_next.prefix_pending = 1'b1;
        end else begin
            state_next.prefix_pending = 1'b0;
            if (in_byte[7]) begin
                if (low == KEY_LCTRL) begin
                    state_next.ctrl_down = 1'b0;
                end else if (!prefixed && (low == KEY_LSHIFT || low == KEY_RSHIFT)) begin
                    state_next.shift_down = 1'b0;
                end else if (low == KEY_ALT) begin
                    state_next.alt_down = 1'b0;
                end
            end else begin
                handled = prefixed ? (low == KEY_ALT || low == KEY_LCTRL)
                                   : (in_byte != 8'h00 && in_byte < KEY_LIMIT);
                if (handled) begin
                    use_shift = (!prefixed && shift_only_key(in_byte))
                              ? state_reg.shift_down
                              : (state_reg.shift_down ^ state_reg.caps_lock_on);
                    ch = key_char(low[IDX_W-1:0], use_shift);
                    if (ch == '0) begin
                        if (low == KEY_LCTRL) begin
                            state_next.ctrl_down = 1'b1;
                        end else if (low == KEY_LSHIFT || low == KEY_RSHIFT) begin
                            state_next.shift_down = 1'b1;
                        end else if (low == KEY_ALT) begin
                            state_next.alt_down = 1'b1;
                        end else if (low == KEY_CAPS) begin
                            state_next.caps_lock_on = !state_reg.caps_lock_on;
                        end
                    end
                end else begin
                    unknown = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        result.char_valid  = (ch != '0);
        result.ascii_char  = ch;
        result.unknown_key = unknown;
        result.ctrl_held   = state_next.ctrl_down;
        result.shift_held  = state_next.shift_down;
        result.alt_held    = state_next.alt_down;
        result.caps_on     = state_next.caps_lock_on;
    end

`ifndef ASSERT_OFF
    a_prefix_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_byte == PREFIX_BYTE |=> state_reg.prefix_pending)
        else $error("prefix byte did not arm prefix");

    a_char_not_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> !(result.char_valid && result.unknown_key))
        else $error("character and unknown flag together");

    a_break_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_byte[7] |-> !result.char_valid && !result.unknown_key)
        else $error("break code produced a character or unknown flag");

    a_caps_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !state_reg.prefix_pending && in_byte == {1'b0, KEY_CAPS}
        |=> state_reg.caps_lock_on != $past(state_reg.caps_lock_on))
        else $error("caps lock make did not toggle");
`endif

endmodule

### design/ksa_out_reg.sv
// Result register: holds one decoded beat until the master side takes it.
// Depends on ksa_pkg.
module ksa_out_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  ksa_pkg::ksa_result_t            result,
    output logic                            advance,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] char_valid, [7:1] ascii_char, [8] unknown_key, [9] ctrl_held,
    // [10] shift_held, [11] alt_held, [12] caps_on, [15:13] zero
    output logic [ksa_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ksa_pkg::*;

    logic        valid_reg, valid_next;
    ksa_result_t res_reg, res_next;

    assign advance = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (advance) begin
            valid_next = in_valid;
            if (in_valid) begin
                res_next = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, res_reg.caps_on, res_reg.alt_held, res_reg.shift_held,
                       res_reg.ctrl_held, res_reg.unknown_key, res_reg.ascii_char,
                       res_reg.char_valid};

endmodule

### tb/tb_top.sv
// Self-checking bench for keyboard_scancode_to_ascii: drives set 1 scan code beats and checks
// every result beat against a local decoder model with its own copy of the modifier state.
// Depends on ksa_pkg and the keyboard_scancode_to_ascii RTL.
module tb_top;
    import ksa_pkg::*;

    localparam int        LONG_HOLD  = 200;
    localparam int        RAND_BEATS = 800;
    localparam logic [7:0] BREAK_BIT = 8'h80;

    localparam logic [15:0] CODE_LCTRL  = {9'h000, KEY_LCTRL};
    localparam logic [15:0] CODE_RCTRL  = {PREFIX_BYTE, 1'b0, KEY_LCTRL};
    localparam logic [15:0] CODE_LSHIFT = {9'h000, KEY_LSHIFT};
    localparam logic [15:0] CODE_RSHIFT = {9'h000, KEY_RSHIFT};
    localparam logic [15:0] CODE_LALT   = {9'h000, KEY_ALT};
    localparam logic [15:0] CODE_RALT   = {PREFIX_BYTE, 1'b0, KEY_ALT};
    localparam logic [15:0] CODE_LIMIT  = {8'h00, KEY_LIMIT};

    localparam logic [7:0] LOWER_KEYS [KEY_COUNT] = '{
        8'h00, 8'h1b, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08, 8'h09,
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0d, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, 8'h00, 8'h5c, "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " ", 8'h00
    };

    localparam logic [7:0] UPPER_KEYS [KEY_COUNT] = '{
        8'h00, 8'h1b, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h08, 8'h09,
        "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0d, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "?", 8'h00, "*", 8'h00, " ", 8'h00
    };

    localparam logic [6:0] MOD_KEYS [5] = '{KEY_LCTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_ALT, KEY_CAPS};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;      // [7:0] scan_byte
    logic                 m_tvalid;
    logic                 m_tready;
    // [0] char_valid, [7:1] ascii_char, [8] unknown_key, [9] ctrl_held,
    // [10] shift_held, [11] alt_held, [12] caps_on, [15:13] zero
    logic [M_TDATA_W-1:0] m_tdata;

    // decoder model state
    logic mdl_prefix;
    logic mdl_ctrl;
    logic mdl_shift;
    logic mdl_alt;
    logic mdl_caps;

    logic [M_TDATA_W-1:0] pending_decodes [$];
    int scans_sent;
    int results_seen;
    int mismatches;
    int extended_sent;
    bit src_idle_on;
    bit sink_idle_on;
    bit long_hold_req;

    keyboard_scancode_to_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic case_by_shift_only(input logic [15:0] code);
        return code < 16'h000e || code == 16'h0029 || code == 16'h001a || code == 16'h001b ||
               code == 16'h002b || code == 16'h0027 || code == 16'h0028 || code == 16'h0033 ||
               code == 16'h0034 || code == 16'h0035;
    endfunction

    // advances the model by one scan byte, returns the expected result beat
    function automatic logic [M_TDATA_W-1:0] decode_scan(input logic [7:0] scan);
        logic [15:0]       code;
        logic [15:0]       mk;
        logic [5:0]        idx;
        logic [7:0]        ch;
        logic              upper;
        logic              unknown;
        logic [M_TDATA_W-1:0] beat;
        ch      = 8'h00;
        unknown = 1'b0;
        if (scan == PREFIX_BYTE) begin
            mdl_prefix = 1'b1;
        end else begin
            code = {8'h00, scan};
            if (mdl_prefix) begin
                code[15:8] = PREFIX_BYTE;
                mdl_prefix = 1'b0;
            end
            if ((code & {8'h00, BREAK_BIT}) != 16'h0000) begin
                mk = code & ~{8'h00, BREAK_BIT};
                if (mk == CODE_RCTRL || mk == CODE_LCTRL)
                    mdl_ctrl = 1'b0;
                else if (mk == CODE_RSHIFT || mk == CODE_LSHIFT)
                    mdl_shift = 1'b0;
                else if (mk == CODE_LALT || mk == CODE_RALT)
                    mdl_alt = 1'b0;
            end else if ((code > 16'h0000 && code < CODE_LIMIT) ||
                         code == CODE_RALT || code == CODE_RCTRL) begin
                idx = code[5:0];
                if (case_by_shift_only(code))
                    upper = mdl_shift;
                else
                    upper = mdl_shift ^ mdl_caps;
                if (int'(idx) < KEY_COUNT)
                    ch = upper ? UPPER_KEYS[idx] : LOWER_KEYS[idx];
                if (ch == 8'h00) begin
                    if (idx == KEY_LCTRL[5:0])
                        mdl_ctrl = 1'b1;
                    else if (idx == KEY_LSHIFT[5:0] || idx == KEY_RSHIFT[5:0])
                        mdl_shift = 1'b1;
                    else if (idx == KEY_ALT[5:0])
                        mdl_alt = 1'b1;
                    else if (idx == KEY_CAPS[5:0])
                        mdl_caps = ~mdl_caps;
                end
            end else begin
                unknown = 1'b1;
            end
        end
        beat = '0;
        beat[0]    = (ch != 8'h00);
        beat[7:1]  = ch[6:0];
        beat[8]    = unknown;
        beat[9]    = mdl_ctrl;
        beat[10]   = mdl_shift;
        beat[11]   = mdl_alt;
        beat[12]   = mdl_caps;
        return beat;
    endfunction

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_scan(input logic [7:0] scan);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= scan;
        do @(posedge aclk); while (!s_tready);
        pending_decodes.push_back(decode_scan(scan));
        scans_sent++;
        if (scan == PREFIX_BYTE)
            extended_sent++;
    endtask

    task automatic flag_field(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                     results_seen, field, want, got);
    endtask

    task automatic check_beat(input logic [M_TDATA_W-1:0] want, input logic [M_TDATA_W-1:0] got);
        if (got[0] !== want[0])     flag_field("char_valid", int'(want[0]), int'(got[0]));
        if (got[7:1] !== want[7:1]) flag_field("ascii_char", int'(want[7:1]), int'(got[7:1]));
        if (got[8] !== want[8])     flag_field("unknown_key", int'(want[8]), int'(got[8]));
        if (got[9] !== want[9])     flag_field("ctrl_held", int'(want[9]), int'(got[9]));
        if (got[10] !== want[10])   flag_field("shift_held", int'(want[10]), int'(got[10]));
        if (got[11] !== want[11])   flag_field("alt_held", int'(want[11]), int'(got[11]));
        if (got[12] !== want[12])   flag_field("caps_on", int'(want[12]), int'(got[12]));
        if (got[15:13] !== want[15:13])
            flag_field("pad", int'(want[15:13]), int'(got[15:13]));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat 0x%0h with nothing expected", m_tdata);
            end else begin
                check_beat(pending_decodes.pop_front(), m_tdata);
            end
            results_seen++;
        end
    end

    // result side: random hold-offs, plus one long hold on request
    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end else if (hold_left == 0) begin
                hold_left = pick_gap(sink_idle_on);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        logic [7:0] seq [$];
        seq = '{
            {1'b0, KEY_LSHIFT}, 8'h1e, 8'h02, {1'b1, KEY_LSHIFT},
            {1'b0, KEY_CAPS}, 8'h10, 8'h02, {1'b1, KEY_CAPS}, {1'b0, KEY_CAPS},
            {1'b0, KEY_LCTRL}, {1'b1, KEY_LCTRL},
            PREFIX_BYTE, PREFIX_BYTE, {1'b0, KEY_ALT},
            PREFIX_BYTE, {1'b1, KEY_ALT},
            PREFIX_BYTE, {1'b0, KEY_LCTRL},
            PREFIX_BYTE, 8'h1c,
            PREFIX_BYTE, {1'b1, KEY_LSHIFT},
            8'h00, KEY_LIMIT, 8'h7f, 8'hff, 8'h39
        };
        foreach (seq[i])
            send_scan(seq[i]);
    endtask

    task automatic send_typing_event();
        int r;
        logic [7:0] k;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            k = 8'($urandom_range(1, 58));
            send_scan(k);
            if ($urandom_range(0, 9) < 7)
                send_scan(k | BREAK_BIT);
        end else if (r < 65) begin
            k = {1'b0, MOD_KEYS[3'($urandom_range(0, 4))]};
            send_scan($urandom_range(0, 1) ? k : (k | BREAK_BIT));
        end else if (r < 80) begin
            send_scan(PREFIX_BYTE);
            case ($urandom_range(0, 4))
                0:       send_scan({1'b0, KEY_LCTRL});
                1:       send_scan({1'b0, KEY_ALT});
                2:       send_scan({1'b1, KEY_LCTRL});
                3:       send_scan({1'b1, KEY_ALT});
                default: send_scan(8'($urandom_range(0, 255)));
            endcase
        end else begin
            send_scan(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_typing(input int beats);
        int stop_at;
        stop_at = scans_sent + beats;
        while (scans_sent < stop_at)
            send_typing_event();
    endtask

    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_typing(100);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        src_idle_on   = 1'b0;
        long_hold_req = 1'b1;
        test_random_typing(40);
        src_idle_on   = 1'b1;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        mdl_prefix    = 1'b0;
        mdl_ctrl      = 1'b0;
        mdl_shift     = 1'b0;
        mdl_alt       = 1'b0;
        mdl_caps      = 1'b0;
        scans_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        extended_sent = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        long_hold_req = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_back_to_back();
        test_random_typing(RAND_BEATS);
        drain_results();

        $display("sent %0d scan code beats (%0d extended prefixes), checked %0d result beats",
                 scans_sent, extended_sent, results_seen);
        $display("covered modifiers, caps lock, break codes, unknown codes and a long stall");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_decodes.size());
        $display("FAIL");
        $finish;
    end

endmodule
